/* rtl/core/cows_pkg.sv */
package cows_pkg;

	localparam int COLUMNS_DEF        = 32;
	localparam int MAX_PROPERTIES_DEF = 16;

	localparam int CMD_W    = 3;
	localparam int COL_W    = 5;
	localparam int IDX_W    = 4;
	localparam int WORD_W   = 32;
	localparam int STATUS_W = 2;
	localparam int CFG_W    = 5;
	localparam int REF_W    = 8;

	localparam logic [CMD_W-1:0] CMD_LOAD   = 3'd0;
	localparam logic [CMD_W-1:0] CMD_GRAB   = 3'd1;
	localparam logic [CMD_W-1:0] CMD_SET    = 3'd2;
	localparam logic [CMD_W-1:0] CMD_GET    = 3'd3;
	localparam logic [CMD_W-1:0] CMD_COMMIT = 3'd4;

	localparam logic [STATUS_W-1:0] ST_OK     = 2'd0;
	localparam logic [STATUS_W-1:0] ST_NOFREE = 2'd1;
	localparam logic [STATUS_W-1:0] ST_RANGE  = 2'd2;

	localparam logic [CFG_W-1:0] PROP_COUNT_RST = 5'd16;
	localparam logic [REF_W-1:0] REF_MAX        = 8'hFF;

	typedef enum logic [3:0] {
		S_CLEAR,
		S_IDLE,
		S_FETCH,
		S_SCAN,
		S_COPY,
		S_COPY_END,
		S_UNPIN_RD,
		S_UNPIN_WR,
		S_DONE
	} state_t;

endpackage

/* rtl/core/cows_cmd_if.sv */
interface cows_cmd_if;
	logic                         valid;
	logic                         ready;
	logic [cows_pkg::CMD_W-1:0]   command;
	logic [cows_pkg::COL_W-1:0]   column;
	logic [cows_pkg::IDX_W-1:0]   index;
	logic [cows_pkg::WORD_W-1:0]  value;

	modport source (output valid, command, column, index, value, input ready);
	modport sink (input valid, command, column, index, value, output ready);
endinterface

/* rtl/core/cows_res_if.sv */
interface cows_res_if;
	logic                           valid;
	logic                           ready;
	logic [cows_pkg::COL_W-1:0]     result_column;
	logic [cows_pkg::WORD_W-1:0]    read_value;
	logic [cows_pkg::STATUS_W-1:0]  status;

	modport source (output valid, result_column, read_value, status, input ready);
	modport sink (input valid, result_column, read_value, status, output ready);
endinterface

/* rtl/core/copy_on_write_snapshot_table.sv */
// Channel    Direction  Handshake      Word
// cmd        in         valid/ready    command, column, index, value
// res        out        valid/ready    result_column, read_value, status
// cfg        in         cfg_we only    property limit (cfg_wdata)
//
// After reset a clearing pass over all COLUMNS * 2**ceil(log2(MAX_PROPERTIES))
// words (512 by default) zeroes both memories; no word is accepted until it ends.
// Load, grab, get, commit and a set that needs no copy go from fetch to done.
// A copying set first scans the reference counts for the lowest free column f, then
// copies the n words of the property count into it, both through one memory port.
// A result waits in the output register while the next word is taken and worked on.
module copy_on_write_snapshot_table #(
	parameter int COLUMNS        = cows_pkg::COLUMNS_DEF,
	parameter int MAX_PROPERTIES = cows_pkg::MAX_PROPERTIES_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	cows_cmd_if.sink                   cmd,
	cows_res_if.source                 res,
	input  logic                       cfg_we,
	input  logic [cows_pkg::CFG_W-1:0] cfg_wdata
);

	localparam int CW     = $clog2(COLUMNS);
	localparam int PW     = (MAX_PROPERTIES > 1) ? $clog2(MAX_PROPERTIES) : 1;
	localparam int VAW    = CW + PW;
	localparam int VDEPTH = COLUMNS << PW;
	localparam int NW     = $clog2(MAX_PROPERTIES + 1);
	localparam int CFGW   = cows_pkg::CFG_W;
	localparam int LW     = (NW > CFGW) ? NW : CFGW;
	localparam int COLW   = cows_pkg::COL_W;
	localparam int WW     = cows_pkg::WORD_W;
	localparam int RW     = cows_pkg::REF_W;
	localparam int SW     = cows_pkg::STATUS_W;
	localparam int OPW    = cows_pkg::CMD_W;

	localparam logic [CW-1:0]  LAST_COL = CW'(COLUMNS - 1);
	localparam logic [LW-1:0]  MAXP_L   = LW'(MAX_PROPERTIES);
	localparam logic [VAW-1:0] LAST_CLR = VAW'(VDEPTH - 1);

	function automatic logic [CW-1:0] col_reduce(input logic [COLW-1:0] c);
		int v;
		v = int'(c);
		for (int k = COLW - 1; k >= 0; k--) begin
			if (v >= (COLUMNS << k)) begin
				v = v - (COLUMNS << k);
			end
		end
		return CW'(v);
	endfunction

	function automatic logic [RW-1:0] sat_inc(input logic [RW-1:0] r);
		return (r == cows_pkg::REF_MAX) ? r : r + RW'(1);
	endfunction

	function automatic logic [RW-1:0] sat_dec(input logic [RW-1:0] r);
		return (r == '0) ? r : r - RW'(1);
	endfunction

	cows_pkg::state_t state_q, state_d;

	logic [CFGW-1:0]    prop_q;
	logic [CW-1:0]      cur_q;
	logic [COLUMNS-1:0] dirty_q;

	logic [OPW-1:0] op_q;
	logic [CW-1:0]  col_q;
	logic [PW-1:0]  idx_q;
	logic [WW-1:0]  val_q;
	logic           in_range_q;

	logic [CW-1:0]  scan_q;
	logic [CW-1:0]  scan_s1;
	logic           scan_valid_s1;
	logic [CW-1:0]  free_q;
	logic [PW-1:0]  copy_k_q;
	logic [PW-1:0]  cp_k_s1;
	logic           cp_valid_s1;
	logic [VAW-1:0] clr_q;

	logic [COLW-1:0] rcol_q;
	logic [WW-1:0]   rval_q;
	logic [SW-1:0]   rst_q;

	logic            out_valid_q;
	logic [COLW-1:0] out_col_q;
	logic [WW-1:0]   out_val_q;
	logic [SW-1:0]   out_st_q;

	logic [WW-1:0] value_mem [VDEPTH];
	logic [RW-1:0] ref_mem [COLUMNS];

	logic           vm_we;
	logic [VAW-1:0] vm_waddr;
	logic [WW-1:0]  vm_wdata;
	logic [VAW-1:0] vm_raddr;
	logic [WW-1:0]  vm_rdata_q;
	logic           rf_we;
	logic [CW-1:0]  rf_waddr;
	logic [RW-1:0]  rf_wdata;
	logic [CW-1:0]  rf_raddr;
	logic [RW-1:0]  rf_rdata_q;

	logic [LW-1:0] n_used;
	logic [CW-1:0] col_in;
	logic          accept;
	logic          out_free;
	logic          clr_last;
	logic          scan_hit;
	logic          scan_end;
	logic          copy_last;
	logic          same_word;
	logic          is_dirty;
	logic          need_copy;

	assign n_used    = (LW'(prop_q) < MAXP_L) ? LW'(prop_q) : MAXP_L;
	assign col_in    = col_reduce(cmd.column);
	assign cmd.ready = (state_q == cows_pkg::S_IDLE);
	assign accept    = cmd.valid && cmd.ready;
	assign out_free  = !out_valid_q || res.ready;
	assign clr_last  = (clr_q == LAST_CLR);
	assign scan_hit  = scan_valid_s1 && (rf_rdata_q == '0);
	assign scan_end  = scan_valid_s1 && (scan_s1 == LAST_COL);
	assign copy_last = ((LW'(copy_k_q) + LW'(1)) == n_used);
	assign same_word = (vm_rdata_q == val_q);
	assign is_dirty  = dirty_q[col_q];
	assign need_copy = (op_q == cows_pkg::CMD_SET) && in_range_q && !same_word && !is_dirty;

	assign res.valid         = out_valid_q;
	assign res.result_column = out_col_q;
	assign res.read_value    = out_val_q;
	assign res.status        = out_st_q;

	always_comb begin
		state_d = state_q;
		case (state_q)
			cows_pkg::S_CLEAR: begin
				if (clr_last) begin
					state_d = cows_pkg::S_IDLE;
				end
			end
			cows_pkg::S_IDLE: begin
				if (accept) begin
					state_d = cows_pkg::S_FETCH;
				end
			end
			cows_pkg::S_FETCH: begin
				state_d = need_copy ? cows_pkg::S_SCAN : cows_pkg::S_DONE;
			end
			cows_pkg::S_SCAN: begin
				if (scan_hit) begin
					state_d = cows_pkg::S_COPY;
				end else if (scan_end) begin
					state_d = cows_pkg::S_DONE;
				end
			end
			cows_pkg::S_COPY: begin
				if (copy_last) begin
					state_d = cows_pkg::S_COPY_END;
				end
			end
			cows_pkg::S_COPY_END: state_d = cows_pkg::S_UNPIN_RD;
			cows_pkg::S_UNPIN_RD: state_d = cows_pkg::S_UNPIN_WR;
			cows_pkg::S_UNPIN_WR: state_d = cows_pkg::S_DONE;
			cows_pkg::S_DONE: begin
				if (out_free) begin
					state_d = cows_pkg::S_IDLE;
				end
			end
			default: state_d = cows_pkg::S_IDLE;
		endcase
	end

	always_comb begin
		vm_we    = 1'b0;
		vm_waddr = {col_q, idx_q};
		vm_wdata = val_q;
		vm_raddr = {col_q, copy_k_q};
		rf_we    = 1'b0;
		rf_waddr = col_q;
		rf_wdata = '0;
		rf_raddr = col_q;
		if (cp_valid_s1) begin
			vm_we    = 1'b1;
			vm_waddr = {free_q, cp_k_s1};
			vm_wdata = (cp_k_s1 == idx_q) ? val_q : vm_rdata_q;
		end
		case (state_q)
			cows_pkg::S_CLEAR: begin
				vm_we    = 1'b1;
				vm_waddr = clr_q;
				vm_wdata = '0;
				rf_waddr = clr_q[CW-1:0];
				if ({1'b0, clr_q} < (VAW + 1)'(COLUMNS)) begin
					rf_we = 1'b1;
				end
			end
			cows_pkg::S_IDLE: begin
				vm_raddr = {col_in, PW'(cmd.index)};
				rf_raddr = (cmd.command == cows_pkg::CMD_GRAB) ? cur_q : col_in;
			end
			cows_pkg::S_FETCH: begin
				case (op_q)
					cows_pkg::CMD_LOAD: begin
						if (in_range_q) begin
							vm_we    = 1'b1;
							vm_waddr = {CW'(0), idx_q};
						end
					end
					cows_pkg::CMD_GRAB: begin
						rf_we    = 1'b1;
						rf_waddr = cur_q;
						rf_wdata = sat_inc(rf_rdata_q);
					end
					cows_pkg::CMD_SET: begin
						if (in_range_q && !same_word && is_dirty) begin
							vm_we = 1'b1;
						end
					end
					cows_pkg::CMD_COMMIT: begin
						rf_we    = 1'b1;
						rf_wdata = is_dirty ? '0 : sat_dec(rf_rdata_q);
					end
					default: ;
				endcase
			end
			cows_pkg::S_SCAN: begin
				rf_raddr = scan_q;
				if (scan_hit) begin
					rf_we    = 1'b1;
					rf_waddr = scan_s1;
					rf_wdata = RW'(1);
				end
			end
			cows_pkg::S_UNPIN_WR: begin
				rf_we    = 1'b1;
				rf_wdata = sat_dec(rf_rdata_q);
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (vm_we) begin
			value_mem[vm_waddr] <= vm_wdata;
		end
		vm_rdata_q <= value_mem[vm_raddr];
	end

	always_ff @(posedge clk) begin
		if (rf_we) begin
			ref_mem[rf_waddr] <= rf_wdata;
		end
		rf_rdata_q <= ref_mem[rf_raddr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= cows_pkg::S_CLEAR;
			prop_q        <= cows_pkg::PROP_COUNT_RST;
			cur_q         <= '0;
			dirty_q       <= '0;
			clr_q         <= '0;
			scan_valid_s1 <= 1'b0;
			cp_valid_s1   <= 1'b0;
			out_valid_q   <= 1'b0;
		end else begin
			state_q       <= state_d;
			scan_valid_s1 <= (state_q == cows_pkg::S_SCAN);
			cp_valid_s1   <= (state_q == cows_pkg::S_COPY);
			if (cfg_we) begin
				prop_q <= cfg_wdata;
			end
			if (state_q == cows_pkg::S_CLEAR && !clr_last) begin
				clr_q <= clr_q + VAW'(1);
			end
			if (state_q == cows_pkg::S_FETCH && op_q == cows_pkg::CMD_COMMIT && is_dirty) begin
				dirty_q[col_q] <= 1'b0;
				cur_q          <= col_q;
			end
			if (state_q == cows_pkg::S_COPY_END) begin
				dirty_q[free_q] <= 1'b1;
			end
			if (state_q == cows_pkg::S_DONE && out_free) begin
				out_valid_q <= 1'b1;
			end else if (res.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_q       <= cmd.command;
			col_q      <= col_in;
			idx_q      <= PW'(cmd.index);
			val_q      <= cmd.value;
			in_range_q <= (LW'(cmd.index) < n_used);
		end
		if (state_q == cows_pkg::S_FETCH) begin
			rcol_q <= (op_q == cows_pkg::CMD_GRAB) ? COLW'(cur_q) : COLW'(col_q);
			rval_q <= (op_q == cows_pkg::CMD_GET && in_range_q) ? vm_rdata_q : '0;
			rst_q  <= (!in_range_q && (op_q inside {cows_pkg::CMD_LOAD, cows_pkg::CMD_SET,
				cows_pkg::CMD_GET})) ? cows_pkg::ST_RANGE : cows_pkg::ST_OK;
			scan_q <= '0;
		end
		scan_s1 <= scan_q;
		if (state_q == cows_pkg::S_SCAN) begin
			if (scan_q != LAST_COL) begin
				scan_q <= scan_q + CW'(1);
			end
			if (scan_hit) begin
				free_q   <= scan_s1;
				copy_k_q <= '0;
			end else if (scan_end) begin
				rst_q <= cows_pkg::ST_NOFREE;
			end
		end
		cp_k_s1 <= copy_k_q;
		if (state_q == cows_pkg::S_COPY && !copy_last) begin
			copy_k_q <= copy_k_q + PW'(1);
		end
		if (state_q == cows_pkg::S_UNPIN_WR) begin
			rcol_q <= COLW'(free_q);
		end
		if (state_q == cows_pkg::S_DONE && out_free) begin
			out_col_q <= rcol_q;
			out_val_q <= rval_q;
			out_st_q  <= rst_q;
		end
	end

endmodule

/* dv/cows_shadow_check.sv */
module cows_shadow_check
	import cows_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	cows_cmd_if              cmd,
	cows_res_if              res,
	input  logic             cfg_we,
	input  logic [CFG_W-1:0] cfg_wdata,
	output int               errors,
	output int               outstanding,
	output int               checked,
	output int               copies,
	output int               nofree_seen,
	output int               range_seen
);

	localparam int NCOL  = COLUMNS_DEF;
	localparam int NPROP = MAX_PROPERTIES_DEF;

	typedef struct packed {
		logic [COL_W-1:0]    column;
		logic [WORD_W-1:0]   word;
		logic [STATUS_W-1:0] code;
	} outcome_t;

	logic [WORD_W-1:0] words [NCOL][NPROP];
	logic [REF_W-1:0]  refs [NCOL];
	logic              dirty [NCOL];
	logic [COL_W-1:0]  current;
	logic [CFG_W-1:0]  prop_count;
	outcome_t          expected_q [$];

	function automatic void unpin(input logic [COL_W-1:0] c);
		if (refs[c] != '0)
			refs[c] = refs[c] - REF_W'(1);
	endfunction

	function automatic outcome_t apply_word(input logic [CMD_W-1:0] op,
			input logic [COL_W-1:0] col, input logic [IDX_W-1:0] idx,
			input logic [WORD_W-1:0] val);
		outcome_t o;
		int n;
		int f;
		bit fits;
		o.column = col;
		o.word = '0;
		o.code = ST_OK;
		n = (int'(prop_count) < NPROP) ? int'(prop_count) : NPROP;
		fits = int'(idx) < n;
		f = -1;
		case (op)
			CMD_LOAD: begin
				if (!fits)
					o.code = ST_RANGE;
				else
					words[0][idx] = val;
			end
			CMD_GRAB: begin
				o.column = current;
				if (refs[current] != REF_MAX)
					refs[current] = refs[current] + REF_W'(1);
			end
			CMD_SET: begin
				if (!fits) begin
					o.code = ST_RANGE;
				end else if (words[col][idx] != val) begin
					if (dirty[col]) begin
						words[col][idx] = val;
					end else begin
						for (int i = NCOL - 1; i >= 0; i--)
							if (refs[i] == '0)
								f = i;
						if (f < 0) begin
							o.code = ST_NOFREE;
							nofree_seen++;
						end else begin
							refs[f] = REF_W'(1);
							for (int j = 0; j < n; j++)
								words[f][j] = words[col][j];
							words[f][idx] = val;
							dirty[f] = 1'b1;
							unpin(col);
							o.column = COL_W'(f);
							copies++;
						end
					end
				end
			end
			CMD_GET: begin
				if (!fits)
					o.code = ST_RANGE;
				else
					o.word = words[col][idx];
			end
			CMD_COMMIT: begin
				if (!dirty[col]) begin
					unpin(col);
				end else begin
					dirty[col] = 1'b0;
					refs[col] = '0;
					current = col;
				end
			end
			default: begin
			end
		endcase
		if (o.code == ST_RANGE)
			range_seen++;
		return o;
	endfunction

	task automatic flag(input string what, input logic [WORD_W-1:0] want,
			input logic [WORD_W-1:0] got);
		errors++;
		if (errors <= 10)
			$display("%0t mismatch on %s: expected %h, got %h", $time, what, want, got);
	endtask

	always @(posedge clk or negedge arst_n) begin
		outcome_t want;
		if (!arst_n) begin
			for (int i = 0; i < NCOL; i++) begin
				for (int j = 0; j < NPROP; j++)
					words[i][j] = '0;
				refs[i] = '0;
				dirty[i] = 1'b0;
			end
			current = '0;
			prop_count = PROP_COUNT_RST;
			expected_q.delete();
			errors = 0;
			outstanding = 0;
			checked = 0;
			copies = 0;
			nofree_seen = 0;
			range_seen = 0;
		end else begin
			if (res.valid && res.ready) begin
				if (expected_q.size() == 0) begin
					flag("result column of an unrequested word", '0,
						WORD_W'(res.result_column));
				end else begin
					want = expected_q.pop_front();
					checked++;
					if (res.result_column !== want.column)
						flag("result column", WORD_W'(want.column),
							WORD_W'(res.result_column));
					if (res.read_value !== want.word)
						flag("read value", want.word, res.read_value);
					if (res.status !== want.code)
						flag("status code", WORD_W'(want.code), WORD_W'(res.status));
				end
			end
			if (cfg_we)
				prop_count = cfg_wdata;
			if (cmd.valid && cmd.ready)
				expected_q.push_back(apply_word(cmd.command, cmd.column, cmd.index,
					cmd.value));
			outstanding = expected_q.size();
		end
	end

endmodule

/* dv/tb_top.sv */
module tb_top;
	import cows_pkg::*;

	localparam int NCOL = COLUMNS_DEF;

	logic             clk = 1'b0;
	logic             arst_n;
	logic             cfg_we;
	logic [CFG_W-1:0] cfg_wdata;
	logic [COL_W-1:0] seen_column;
	bit               calm;
	int               sent;
	int               live_count;
	int               errors;
	int               outstanding;
	int               checked;
	int               copies;
	int               nofree_seen;
	int               range_seen;

	cows_cmd_if cmd ();
	cows_res_if res ();

	copy_on_write_snapshot_table dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.res       (res),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata)
	);

	cows_shadow_check shadow (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.res         (res),
		.cfg_we      (cfg_we),
		.cfg_wdata   (cfg_wdata),
		.errors      (errors),
		.outstanding (outstanding),
		.checked     (checked),
		.copies      (copies),
		.nofree_seen (nofree_seen),
		.range_seen  (range_seen)
	);

	always #6 clk = ~clk;

	always @(posedge clk) begin
		if (res.valid && res.ready)
			seen_column <= res.result_column;
	end

	initial begin
		#(12 * 1000000);
		$display("status: fail");
		$finish;
	end

	function automatic logic [WORD_W-1:0] pick_word();
		case ($urandom_range(0, 4))
			0: return $urandom_range(0, 3);
			1: return '1;
			2: return '0;
			default: return $urandom;
		endcase
	endfunction

	function automatic logic [COL_W-1:0] pick_column();
		if ($urandom_range(0, 1) == 0)
			return COL_W'($urandom_range(0, 7));
		return COL_W'($urandom_range(0, NCOL - 1));
	endfunction

	task automatic send(input logic [CMD_W-1:0] op, input logic [COL_W-1:0] col,
			input logic [IDX_W-1:0] idx, input logic [WORD_W-1:0] val);
		int gap;
		gap = calm ? 0 : $urandom_range(0, 13);
		if (gap > 0) begin
			cmd.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		cmd.valid <= 1'b1;
		cmd.command <= op;
		cmd.column <= col;
		cmd.index <= idx;
		cmd.value <= val;
		do @(posedge clk); while (!cmd.ready);
		@(negedge clk);
		sent++;
	endtask

	task automatic settle();
		cmd.valid <= 1'b0;
		do @(negedge clk); while (outstanding != 0);
	endtask

	task automatic write_count(input logic [CFG_W-1:0] v);
		settle();
		repeat (4) @(negedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		@(negedge clk);
		cfg_we <= 1'b0;
		live_count = (int'(v) < MAX_PROPERTIES_DEF) ? int'(v) : MAX_PROPERTIES_DEF;
	endtask

	task automatic grab_column(output logic [COL_W-1:0] c);
		send(CMD_GRAB, COL_W'($urandom_range(0, NCOL - 1)), IDX_W'($urandom_range(0, 15)),
			$urandom);
		settle();
		c = seen_column;
	endtask

	task automatic noise_burst();
		repeat ($urandom_range(4, 16))
			send(CMD_W'($urandom_range(0, 7)), pick_column(),
				IDX_W'($urandom_range(0, 15)), pick_word());
	endtask

	// A reader pins the published column, edits it (the first edit moves it to a
	// private copy) and publishes the result.
	task automatic edit_session();
		logic [COL_W-1:0] c;
		grab_column(c);
		repeat ($urandom_range(2, 10)) begin
			case ($urandom_range(0, 5))
				0, 1, 2: begin
					send(CMD_SET, c, IDX_W'($urandom_range(0, 15)), pick_word());
					if ($urandom_range(0, 1) == 0) begin
						settle();
						c = seen_column;
					end
				end
				3: send(CMD_GET, c, IDX_W'($urandom_range(0, 15)), $urandom);
				4: send(CMD_COMMIT, pick_column(), IDX_W'($urandom_range(0, 15)), $urandom);
				default: send(CMD_W'($urandom_range(0, 7)), pick_column(),
					IDX_W'($urandom_range(0, 15)), pick_word());
			endcase
		end
		send(CMD_COMMIT, c, IDX_W'($urandom_range(0, 15)), $urandom);
	endtask

	// Pin the published column heavily, then copy it until no column is free,
	// and finally commit every column once, publishing each private copy and unpinning the rest.
	task automatic fill_session();
		logic [COL_W-1:0] c;
		int span;
		span = (live_count > 0) ? live_count - 1 : 15;
		grab_column(c);
		repeat (36)
			send(CMD_GRAB, COL_W'($urandom_range(0, NCOL - 1)),
				IDX_W'($urandom_range(0, 15)), $urandom);
		repeat (40)
			send(CMD_SET, c, IDX_W'($urandom_range(0, span)), $urandom | 32'h1);
		for (int k = 0; k < NCOL; k++)
			send(CMD_COMMIT, COL_W'(k), IDX_W'($urandom_range(0, 15)), $urandom);
	endtask

	initial begin : drive_ready
		int w;
		res.ready = 1'b0;
		forever begin
			w = calm ? 0 : $urandom_range(0, 13);
			if (w > 0) begin
				res.ready <= 1'b0;
				repeat (w) @(negedge clk);
			end
			res.ready <= 1'b1;
			do @(posedge clk); while (!(res.valid && res.ready));
			@(negedge clk);
		end
	end

	initial begin : stimulus
		int counts [8];
		int goal;
		int pick;
		counts = '{16, 1, 31, 0, 9, 16, 2, 17};
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_wdata = '0;
		cmd.valid = 1'b0;
		cmd.command = '0;
		cmd.column = '0;
		cmd.index = '0;
		cmd.value = '0;
		calm = 1'b0;
		sent = 0;
		live_count = MAX_PROPERTIES_DEF;
		repeat (4) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		send(CMD_LOAD, 5'd0, 4'd0, 32'hFFFF_FFFF);
		send(CMD_LOAD, 5'd31, 4'd15, 32'h8000_0001);
		send(CMD_GET, 5'd0, 4'd0, 32'h0);
		send(CMD_GET, 5'd31, 4'd15, 32'h0);
		send(CMD_GRAB, 5'd31, 4'd15, 32'hFFFF_FFFF);
		// Writing back the same word leaves the pinned column alone.
		send(CMD_SET, 5'd0, 4'd0, 32'hFFFF_FFFF);
		send(CMD_SET, 5'd0, 4'd3, 32'h0000_0001);
		send(CMD_SET, 5'd1, 4'd4, 32'h0000_0007);
		send(CMD_GET, 5'd1, 4'd3, 32'h0);
		send(CMD_COMMIT, 5'd1, 4'd0, 32'h0);
		send(CMD_COMMIT, 5'd5, 4'd0, 32'h0);
		send(CMD_SET, 5'd31, 4'd2, 32'h0000_0005);
		send(CMD_GRAB, 5'd0, 4'd0, 32'h0);
		// Here the lowest free column is the source column itself.
		send(CMD_SET, 5'd2, 4'd1, 32'h0000_0009);
		send(CMD_COMMIT, 5'd0, 4'd0, 32'h0);
		send(3'd5, 5'd31, 4'd15, 32'hFFFF_FFFF);
		send(3'd6, 5'd0, 4'd0, 32'h0);
		send(3'd7, 5'd17, 4'd9, 32'h1234_5678);
		send(CMD_SET, 5'd0, 4'd15, 32'h0);
		write_count(5'd1);
		send(CMD_LOAD, 5'd0, 4'd1, 32'hDEAD_BEEF);
		send(CMD_SET, 5'd0, 4'd15, 32'h0000_0003);
		send(CMD_GET, 5'd0, 4'd1, 32'h0);
		send(CMD_GET, 5'd0, 4'd0, 32'h0);
		send(CMD_LOAD, 5'd0, 4'd0, 32'h0);

		for (int p = 0; p < 8; p++) begin
			write_count(CFG_W'(counts[p]));
			goal = sent + 175;
			calm = 1'b0;
			if (p == 0 || p == 4)
				fill_session();
			if (p == 5)
				repeat (260)
					send(CMD_GRAB, pick_column(), IDX_W'($urandom_range(0, 15)), $urandom);
			while (sent < goal) begin
				calm = ($urandom_range(0, 3) == 0);
				pick = $urandom_range(0, 99);
				if (pick < 55)
					edit_session();
				else if (pick < 97)
					noise_burst();
				else
					fill_session();
			end
		end

		settle();
		repeat (40) @(negedge clk);
		$display("Checked %0d results from %0d commands over eight property counts 0 to 31.",
			checked, sent);
		$display("Seen: %0d copying sets, %0d refused for want of a free column, %0d out of range.",
			copies, nofree_seen, range_seen);
		if (errors == 0 && outstanding == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule
